FILE: hw/rtl/srect_pkg.sv
package srect_pkg;

    // Coordinate width; extents are one bit narrower and never negative.
    localparam int COORD_BITS = 16;
    // Width of a coordinate difference.
    localparam int DW = COORD_BITS + 1;
    // Width of a difference measured from a far edge (corner plus extent).
    localparam int FW = COORD_BITS + 2;
    // Width of one product of two differences.
    localparam int PW = 2 * DW;
    // Width of a sum of up to three products.
    localparam int NW = PW + 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [COORD_BITS-2:0] ext_t;
    typedef logic signed [DW-1:0]         diff_t;
    typedef logic signed [FW-1:0]         far_t;
    typedef logic signed [PW-1:0]         prod_t;
    typedef logic signed [NW-1:0]         wide_t;

    // One query as held in the input register.
    typedef struct packed {
        coord_t x1;
        coord_t y1;
        coord_t x2;
        coord_t y2;
        coord_t cx;
        coord_t cy;
        ext_t   w;
        ext_t   h;
    } item_t;

    // Differences and products shared by the left, right, top and bottom edge tests.
    typedef struct packed {
        diff_t dx;     // x2 - x1
        diff_t dy;     // y2 - y1
        far_t  ua_l;   // cx - x1
        far_t  ua_r;   // cx + w - x1
        far_t  ua_t;   // cy - y1
        far_t  ua_b;   // cy + h - y1
        prod_t p1;     // dx * (y1 - cy)
        prod_t p2;     // dy * (x1 - cx)
        prod_t p3;     // dy * w
        prod_t p4;     // dx * h
        logic  w_nz;
        logic  h_nz;
    } geo_t;

    typedef struct packed {
        logic left;
        logic right;
        logic top;
        logic bottom;
    } flags_t;

    // True when n / d lies in [0, 1]; d must be non-zero.
    function automatic logic in_unit(input wide_t n, input wide_t d);
        logic r;
        if (d > 0)
        begin
            r = (n >= 0) && (n <= d);
        end
        else
        begin
            r = (n <= 0) && (n >= d);
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/srect_prod.sv
// Differences and the four cross products that all edge tests share.
module srect_prod (
    input  srect_pkg::item_t item,
    output srect_pkg::geo_t  geo
);
    import srect_pkg::*;

    diff_t ox;
    diff_t oy;
    diff_t w_s;
    diff_t h_s;
    diff_t fx;
    diff_t fy;

    always_comb
    begin
        ox  = DW'(item.x1) - DW'(item.cx);
        oy  = DW'(item.y1) - DW'(item.cy);
        w_s = $signed({2'b00, item.w});
        h_s = $signed({2'b00, item.h});
        fx  = DW'(item.cx) + w_s;
        fy  = DW'(item.cy) + h_s;

        geo.dx   = DW'(item.x2) - DW'(item.x1);
        geo.dy   = DW'(item.y2) - DW'(item.y1);
        geo.ua_l = FW'(item.cx) - FW'(item.x1);
        geo.ua_r = FW'(fx) - FW'(item.x1);
        geo.ua_t = FW'(item.cy) - FW'(item.y1);
        geo.ua_b = FW'(fy) - FW'(item.y1);
        geo.p1   = geo.dx * oy;
        geo.p2   = geo.dy * ox;
        geo.p3   = geo.dy * w_s;
        geo.p4   = geo.dx * h_s;
        geo.w_nz = (item.w != '0);
        geo.h_nz = (item.h != '0);
    end

endmodule

FILE: hw/rtl/srect_test.sv
// Range tests of both parameters for the left, right, top and bottom edges.
module srect_test (
    input  srect_pkg::geo_t   geo,
    output srect_pkg::flags_t flags
);
    import srect_pkg::*;

    wide_t nb_lt;
    wide_t nb_r;
    wide_t nb_b;
    wide_t d_lr;
    wide_t d_tb;
    logic  vert_ok;
    logic  horz_ok;

    always_comb
    begin
        // The left and top edges start at the corner, so they share one numerator.
        nb_lt = NW'(geo.p1) - NW'(geo.p2);
        nb_r  = nb_lt + NW'(geo.p3);
        nb_b  = nb_lt - NW'(geo.p4);
        d_lr  = NW'(geo.p4);
        d_tb  = -NW'(geo.p3);

        vert_ok = geo.h_nz && (geo.dx != '0);
        horz_ok = geo.w_nz && (geo.dy != '0);

        flags.left   = vert_ok && in_unit(NW'(geo.ua_l), NW'(geo.dx))
                       && in_unit(nb_lt, d_lr);
        flags.right  = vert_ok && in_unit(NW'(geo.ua_r), NW'(geo.dx))
                       && in_unit(nb_r, d_lr);
        flags.top    = horz_ok && in_unit(NW'(geo.ua_t), NW'(geo.dy))
                       && in_unit(nb_lt, d_tb);
        flags.bottom = horz_ok && in_unit(NW'(geo.ua_b), NW'(geo.dy))
                       && in_unit(nb_b, d_tb);
    end

endmodule

FILE: hw/rtl/segment_rectangle_intersect.sv
// Segment against rectangle intersection. Each transfer on the input channel
// carries a segment and an axis-aligned box in signed pixel coordinates; the
// block reports, for each of the box's sides (left, right, top, bottom), whether the segment meets
// it (end points touching an edge count), plus the OR of the four. A segment
// parallel to an edge, a zero-length segment or a zero-length edge gives no
// hit on that edge, and a segment lying wholly inside the box is no hit. The
// arithmetic is exact: no rounding and no wrap. The block takes one query
// every clock unless held off by a stall; a query passes through the input
// register and then the result register, and the work in between is a
// single pass through four parallel 17 by 17 bit multipliers followed by
// the sums and range compares, and that pass sets the clock.
// A stall on the output holds the result register and, once the input
// register is full too, is passed back to the input as a stall.
module segment_rectangle_intersect (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  srect_pkg::coord_t   seg_start_x,
    input  srect_pkg::coord_t   seg_start_y,
    input  srect_pkg::coord_t   seg_end_x,
    input  srect_pkg::coord_t   seg_end_y,
    input  srect_pkg::coord_t   box_corner_x,
    input  srect_pkg::coord_t   box_corner_y,
    input  srect_pkg::ext_t     box_size_x,
    input  srect_pkg::ext_t     box_size_y,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                hit,
    output logic                hit_left,
    output logic                hit_right,
    output logic                hit_top,
    output logic                hit_bottom
);
    import srect_pkg::*;

    // Input register.
    logic   s1_valid_reg;
    logic   s1_valid_next;
    item_t  item_reg;

    // Result register.
    logic   out_valid_reg;
    logic   out_valid_next;
    flags_t flags_reg;
    logic   hit_reg;

    geo_t   geo;
    flags_t flags;
    logic   out_load;
    logic   in_take;

    // The result register takes a new item whenever it is empty or its
    // current result is being transferred out in this cycle.
    always_comb
    begin
        out_load       = s1_valid_reg && (!out_valid_reg || !out_stall);
        in_stall       = s1_valid_reg && !out_load;
        in_take        = in_valid && !in_stall;
        s1_valid_next  = in_take || (s1_valid_reg && !out_load);
        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset; they are qualified by the valid bits.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.x1 <= seg_start_x;
            item_reg.y1 <= seg_start_y;
            item_reg.x2 <= seg_end_x;
            item_reg.y2 <= seg_end_y;
            item_reg.cx <= box_corner_x;
            item_reg.cy <= box_corner_y;
            item_reg.w  <= box_size_x;
            item_reg.h  <= box_size_y;
        end
        if (out_load)
        begin
            flags_reg <= flags;
            hit_reg   <= flags.left || flags.right || flags.top || flags.bottom;
        end
    end

    srect_prod u_prod (
        .item (item_reg),
        .geo  (geo)
    );

    srect_test u_test (
        .geo   (geo),
        .flags (flags)
    );

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign hit_left   = flags_reg.left;
    assign hit_right  = flags_reg.right;
    assign hit_top    = flags_reg.top;
    assign hit_bottom = flags_reg.bottom;

    // An empty input register never holds the input back.
    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled while the input register is empty");

    // A held item moves to the result register when the output is free.
    a_item_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_stall) |=> out_valid)
        else $error("held item did not reach the result register");

    // The summary flag agrees with the edge flags for every result.
    a_hit_summary: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hit == (hit_left || hit_right || hit_top || hit_bottom)))
        else $error("summary hit disagrees with the edge flags");

    // A box of zero height has degenerate vertical edges, which are never hit.
    a_flat_box: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (!hit_left && !hit_right) || $past(item_reg.h != '0))
        else $error("vertical edge hit on a box of zero height");

    // A box of zero width has degenerate horizontal edges.
    a_thin_box: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (!hit_top && !hit_bottom) || $past(item_reg.w != '0))
        else $error("horizontal edge hit on a box of zero width");

endmodule

FILE: tb/srect_checker.sv
module srect_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  srect_pkg::coord_t seg_start_x,
    input  srect_pkg::coord_t seg_start_y,
    input  srect_pkg::coord_t seg_end_x,
    input  srect_pkg::coord_t seg_end_y,
    input  srect_pkg::coord_t box_corner_x,
    input  srect_pkg::coord_t box_corner_y,
    input  srect_pkg::ext_t   box_size_x,
    input  srect_pkg::ext_t   box_size_y,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic              hit,
    input  logic              hit_left,
    input  logic              hit_right,
    input  logic              hit_top,
    input  logic              hit_bottom,
    output int                fail_count,
    output int                results_due,
    output int                results_checked,
    output int                hit_count
);

    import srect_pkg::*;

    // Edge flags still owed by the block, oldest first.
    flags_t hits_due[$];

    function automatic logic ratio_in_unit(input longint num, input longint den);
        if (den > 0)
        begin
            return (num >= 0) && (num <= den);
        end
        return (num <= 0) && (num >= den);
    endfunction

    // Parametric test of segment (x1,y1)-(x2,y2) against edge (x3,y3)-(x4,y4).
    function automatic logic meets_edge(input longint x1, input longint y1,
                                        input longint x2, input longint y2,
                                        input longint x3, input longint y3,
                                        input longint x4, input longint y4);
        longint sdx, sdy, edx, edy, ox, oy, den, num_a, num_b;
        sdx   = x2 - x1;
        sdy   = y2 - y1;
        edx   = x4 - x3;
        edy   = y4 - y3;
        ox    = x1 - x3;
        oy    = y1 - y3;
        den   = edy * sdx - edx * sdy;
        num_a = edx * oy - edy * ox;
        num_b = sdx * oy - sdy * ox;
        if (den == 0)
        begin
            return 1'b0;
        end
        return ratio_in_unit(num_a, den) && ratio_in_unit(num_b, den);
    endfunction

    function automatic flags_t predict_hits(input coord_t x1, input coord_t y1,
                                            input coord_t x2, input coord_t y2,
                                            input coord_t cx, input coord_t cy,
                                            input ext_t w, input ext_t h);
        longint lx1, ly1, lx2, ly2, lcx, lcy, far_x, far_y;
        flags_t f;
        lx1   = x1;
        ly1   = y1;
        lx2   = x2;
        ly2   = y2;
        lcx   = cx;
        lcy   = cy;
        far_x = lcx + longint'(w);
        far_y = lcy + longint'(h);
        f.left   = meets_edge(lx1, ly1, lx2, ly2, lcx, lcy, lcx, far_y);
        f.right  = meets_edge(lx1, ly1, lx2, ly2, far_x, lcy, far_x, far_y);
        f.top    = meets_edge(lx1, ly1, lx2, ly2, lcx, lcy, far_x, lcy);
        f.bottom = meets_edge(lx1, ly1, lx2, ly2, lcx, far_y, far_x, far_y);
        return f;
    endfunction

    function automatic int field_mismatch(input string name, input logic want,
                                          input logic got);
        if (got !== want)
        begin
            $error("%s: expected %0b, got %0b", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        flags_t want;
        int     bad;
        if (!rst_n)
        begin
            hits_due.delete();
            fail_count      <= 0;
            results_due     <= 0;
            results_checked <= 0;
            hit_count       <= 0;
        end
        else
        begin
            bad = 0;
            // A result never leaves in the same cycle as its query arrives,
            // so the output is settled before the input is queued.
            if (out_valid && !out_stall)
            begin
                if (hits_due.size() == 0)
                begin
                    $error("result transfer with no query outstanding");
                    bad = 1;
                end
                else
                begin
                    want = hits_due.pop_front();
                    bad += field_mismatch("hit", |want, hit);
                    bad += field_mismatch("hit_left", want.left, hit_left);
                    bad += field_mismatch("hit_right", want.right, hit_right);
                    bad += field_mismatch("hit_top", want.top, hit_top);
                    bad += field_mismatch("hit_bottom", want.bottom, hit_bottom);
                    results_checked <= results_checked + 1;
                    hit_count       <= hit_count + ((|want) ? 1 : 0);
                end
            end
            if (in_valid && !in_stall)
            begin
                hits_due.push_back(predict_hits(seg_start_x, seg_start_y,
                                                seg_end_x, seg_end_y,
                                                box_corner_x, box_corner_y,
                                                box_size_x, box_size_y));
            end
            fail_count  <= fail_count + bad;
            results_due <= hits_due.size();
        end
    end

endmodule

FILE: tb/tb_segment_rectangle_intersect.sv
module tb_segment_rectangle_intersect;

    import srect_pkg::*;

    // This bound on the run only catches a block that has hung or stopped
    // handing results out.
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 700;
    // Room around a box inside which random segment end points are placed, so
    // that most random segments actually come near the box.
    localparam int MARGIN        = 32;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_stall;
    coord_t seg_start_x;
    coord_t seg_start_y;
    coord_t seg_end_x;
    coord_t seg_end_y;
    coord_t box_corner_x;
    coord_t box_corner_y;
    ext_t   box_size_x;
    ext_t   box_size_y;
    logic   out_valid;
    logic   out_stall;
    logic   hit;
    logic   hit_left;
    logic   hit_right;
    logic   hit_top;
    logic   hit_bottom;

    int fail_count;
    int results_due;
    int results_checked;
    int hit_count;
    int cycle_count;
    int queries_sent;
    int directed_sent;

    // While set, neither side idles: back-to-back transfers at full rate.
    bit steady;

    segment_rectangle_intersect uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .seg_start_x  (seg_start_x),
        .seg_start_y  (seg_start_y),
        .seg_end_x    (seg_end_x),
        .seg_end_y    (seg_end_y),
        .box_corner_x (box_corner_x),
        .box_corner_y (box_corner_y),
        .box_size_x   (box_size_x),
        .box_size_y   (box_size_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit),
        .hit_left     (hit_left),
        .hit_right    (hit_right),
        .hit_top      (hit_top),
        .hit_bottom   (hit_bottom)
    );

    // The checker sits beside the block, watches both channels, predicts each
    // result and compares it; it hands back its failure count, how many results
    // are still owed, how many it has checked and how many met the box.
    srect_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .seg_start_x     (seg_start_x),
        .seg_start_y     (seg_start_y),
        .seg_end_x       (seg_end_x),
        .seg_end_y       (seg_end_y),
        .box_corner_x    (box_corner_x),
        .box_corner_y    (box_corner_y),
        .box_size_x      (box_size_x),
        .box_size_y      (box_size_y),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .hit             (hit),
        .hit_left        (hit_left),
        .hit_right       (hit_right),
        .hit_top         (hit_top),
        .hit_bottom      (hit_bottom),
        .fail_count      (fail_count),
        .results_due     (results_due),
        .results_checked (results_checked),
        .hit_count       (hit_count)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // The receiver stalls at random with a chance of about ten percent, except
    // during reset and during the steady stretch.
    always @(posedge clk)
    begin
        out_stall <= rst_n && !steady && ($urandom_range(99) < 10);
    end

    // Watchdog: a hung block ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Saturates a wide integer into the signed coordinate range, so that
    // points generated around a box near the edge of the plane stay legal.
    function automatic coord_t to_coord(input int v);
        if (v > 32767)
        begin
            return coord_t'(32767);
        end
        if (v < -32768)
        begin
            return coord_t'(-32768);
        end
        return coord_t'(v);
    endfunction

    // Offers one query and returns once it has been transferred. Before the
    // query the sender may idle with valid low; valid is only ever set once
    // per clock edge, and the payload is held for as long as the block stalls.
    task automatic send_query(input int x1, input int y1,
                              input int x2, input int y2,
                              input int cx, input int cy,
                              input int w, input int h);
        int gap;
        if (!steady && $urandom_range(99) < 4)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        seg_start_x  <= to_coord(x1);
        seg_start_y  <= to_coord(y1);
        seg_end_x    <= to_coord(x2);
        seg_end_y    <= to_coord(y2);
        box_corner_x <= to_coord(cx);
        box_corner_y <= to_coord(cy);
        box_size_x   <= ext_t'(w);
        box_size_y   <= ext_t'(h);
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        queries_sent++;
    endtask

    // Most random queries place a small box anywhere in the plane and put the
    // segment close to it, so that crossings, near misses and segments wholly
    // inside all turn up often. Some are made parallel to the axes or reduced
    // to a point, some start exactly on an edge, and a share is plain noise
    // over the whole coordinate range.
    task automatic random_query();
        int kind, cx, cy, w, h, x1, y1, x2, y2;
        kind = $urandom_range(99);
        cx   = $urandom_range(65535) - 32768;
        cy   = $urandom_range(65535) - 32768;
        if ($urandom_range(9) == 0)
        begin
            w = $urandom_range(32767);
            h = $urandom_range(32767);
        end
        else
        begin
            w = $urandom_range(48);
            h = $urandom_range(48);
        end
        x1 = cx - MARGIN + $urandom_range(w + 2 * MARGIN);
        y1 = cy - MARGIN + $urandom_range(h + 2 * MARGIN);
        x2 = cx - MARGIN + $urandom_range(w + 2 * MARGIN);
        y2 = cy - MARGIN + $urandom_range(h + 2 * MARGIN);
        if (kind < 15)
        begin
            x1 = $urandom_range(65535) - 32768;
            y1 = $urandom_range(65535) - 32768;
            x2 = $urandom_range(65535) - 32768;
            y2 = $urandom_range(65535) - 32768;
        end
        else if (kind < 30)
        begin
            case ($urandom_range(2))
                0: y2 = y1;
                1: x2 = x1;
                default:
                begin
                    x2 = x1;
                    y2 = y1;
                end
            endcase
        end
        else if (kind < 45)
        begin
            case ($urandom_range(3))
                0:
                begin
                    x1 = cx;
                    y1 = cy + $urandom_range(h);
                end
                1:
                begin
                    x1 = cx + w;
                    y1 = cy + $urandom_range(h);
                end
                2:
                begin
                    x1 = cx + $urandom_range(w);
                    y1 = cy;
                end
                default:
                begin
                    x1 = cx + $urandom_range(w);
                    y1 = cy + h;
                end
            endcase
        end
        send_query(x1, y1, x2, y2, cx, cy, w, h);
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        seg_start_x  <= '0;
        seg_start_y  <= '0;
        seg_end_x    <= '0;
        seg_end_y    <= '0;
        box_corner_x <= '0;
        box_corner_y <= '0;
        box_size_x   <= '0;
        box_size_y   <= '0;
        steady        = 1'b0;
        queries_sent  = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed queries against a 10 by 10 box at the origin unless noted.
        // Horizontal segment through both side edges, and the same reversed.
        send_query(-10, 5, 20, 5, 0, 0, 10, 10);
        send_query(20, 5, -10, 5, 0, 0, 10, 10);
        // Vertical segment through the top and bottom edges.
        send_query(5, -10, 5, 20, 0, 0, 10, 10);
        // Segment wholly inside the box: no edge is crossed, so no hit.
        send_query(2, 2, 8, 8, 0, 0, 10, 10);
        // Segment well clear of the box.
        send_query(20, 20, 30, 25, 0, 0, 10, 10);
        // Segment lying along the top edge: parallel to it, so the top edge
        // itself gives nothing while the side edges are touched.
        send_query(-5, 0, 15, 0, 0, 0, 10, 10);
        // A point on the top edge: degenerate segment, never a hit.
        send_query(5, 0, 5, 0, 0, 0, 10, 10);
        // Zero-width box: top and bottom edges have no length.
        send_query(-5, 5, 5, 5, 0, 0, 0, 10);
        // Box shrunk to a single point.
        send_query(-5, -5, 5, 5, 0, 0, 0, 0);
        // End point just touching the left edge, and the right edge.
        send_query(-5, 5, 0, 5, 0, 0, 10, 10);
        send_query(15, 3, 10, 7, 0, 0, 10, 10);
        // Diagonal passing exactly through two opposite corners.
        send_query(-5, -5, 15, 15, 0, 0, 10, 10);
        // Segment touching the box only at a corner from outside.
        send_query(10, 10, 20, 20, 0, 0, 10, 10);
        // Extremes of the plane: the full diagonal against the largest box.
        send_query(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
        // Corner at the top of the range with the largest extents: the far
        // edges lie beyond the coordinate range and must not wrap round.
        send_query(32767, -32768, 32767, 32767, 32767, 32767, 32767, 32767);
        send_query(32767, 32767, -32768, -32768, 32767, 32767, 32767, 32767);
        send_query(32760, 0, 32767, 0, 32700, -10, 32767, 20);
        // Corner at the bottom of the range, segment crossing the left edge.
        send_query(-32768, -32760, 0, -32760, -32767, -32768, 100, 100);
        // All-ones patterns in every field, then the extremes against the largest box at the origin.
        send_query(-1, -1, -1, -1, -1, -1, 32767, 32767);
        send_query(32767, -32768, -32768, 32767, 0, 0, 32767, 32767);
        directed_sent = queries_sent;

        // Hold the sender off until every directed result has been checked,
        // so that the block drains completely at least once.
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (results_due != 0);

        // Random part, with a stretch in the middle where neither side idles.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            steady = (i >= 300) && (i < 450);
            random_query();
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        // Wait for the last results, then let the clock run on so that any stray
        // result transfer would be flagged by the checker.
        do
        begin
            @(posedge clk);
        end
        while (results_due != 0);
        repeat (8) @(posedge clk);

        $display("Checked %0d of %0d queries (%0d directed, rest random); %0d met the box.",
                 results_checked, queries_sent, directed_sent, hit_count);
        $display("Both sides idled at random, with one full-rate stretch and one drain.");
        if (fail_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
